>>> design/mst_pkg.sv
// Shared types, codes and helpers for the monomial set toggle/sort core.
// Standalone package; used by the interfaces and every module of the core.
`default_nettype none
package mst_pkg;

   localparam int MST_VARS  = 32;
   localparam int MST_DEPTH = 32;

   localparam int MaskW = 32;
   localparam int DegW  = 6;
   localparam int KeyW  = DegW + MaskW;

   localparam logic [1:0] FN_TOGGLE = 2'd0;
   localparam logic [1:0] FN_DUMP   = 2'd1;
   localparam logic [1:0] FN_CLEAR  = 2'd2;

   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_REMOVED = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_CLEARED = 3'd3;
   localparam logic [2:0] ST_DUMPED  = 3'd4;

   typedef struct packed {
      logic [MaskW-1:0] mask;
      logic [DegW-1:0]  degree;
   } entry_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [MaskW-1:0] term_mask;
      logic [DegW-1:0]  term_degree;
      logic             term_valid;
      logic [5:0]       term_count;
      logic             last;
   } res_type;

   // Ascending key: degree first, then the term holding the lowest
   // differing variable wins, i.e. larger bit-reversed mask first.
   function automatic logic [KeyW-1:0] sort_key(input entry_type e);
      logic [MaskW-1:0] rev;
      for (int i = 0; i < MaskW; i++) begin
         rev[i] = e.mask[MaskW-1-i];
      end
      return {e.degree, ~rev};
   endfunction

endpackage
`default_nettype wire

>>> design/mst_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on mst_pkg.
`default_nettype none
interface mst_req_if import mst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       func;
   logic [MaskW-1:0] mono_mask;
   modport source(output valid, func, mono_mask, input ready);
   modport sink(input valid, func, mono_mask, output ready);
endinterface

interface mst_rsp_if import mst_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic [MaskW-1:0] term_mask;
   logic [DegW-1:0]  term_degree;
   logic             term_valid;
   logic [5:0]       term_count;
   logic             last;
   modport source(output valid, status, term_mask, term_degree, term_valid,
                  term_count, last, input ready);
   modport sink(input valid, status, term_mask, term_degree, term_valid,
                term_count, last, output ready);
endinterface
`default_nettype wire

>>> design/mst_mem.sv
// Term store: DEPTH entries of mask and degree, one write and one read port,
// registered read data. Depends on mst_pkg.
`default_nettype none
module mst_mem import mst_pkg::*; #(
   parameter int DEPTH = MST_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire entry_type                wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                     rd_data
);
   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> design/mst_seq.sv
// Sequencer: match scan, compaction, append and selection-sort dump over
// the term store. Depends on mst_pkg; drives mst_mem.
`default_nettype none
module mst_seq import mst_pkg::*; #(
   parameter int VARS  = MST_VARS,
   parameter int DEPTH = MST_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic [1:0]               req_func,
   input  wire logic [MaskW-1:0]         req_mask,
   output logic                          req_ready,
   input  wire logic                     res_ready,
   output logic                          res_valid,
   output res_type                       res,
   output logic                          wr_en,
   output logic [$clog2(DEPTH)-1:0]      wr_addr,
   output entry_type                     wr_data,
   output logic [$clog2(DEPTH)-1:0]      rd_addr,
   input  wire entry_type                rd_data
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] Full = CW'(DEPTH);
   localparam logic [MaskW-1:0] VarMask =
      (VARS >= MaskW) ? {MaskW{1'b1}} : MaskW'((64'd1 << VARS) - 64'd1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_COMPACT = 3'd2;
   localparam logic [2:0] S_DSCAN   = 3'd3;
   localparam logic [2:0] S_RESP    = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [AW-1:0]    chk_idx_ff, chk_idx_in;
   entry_type        new_ff, new_in;
   logic [KeyW-1:0]  prev_key_ff, prev_key_in;
   logic             have_prev_ff, have_prev_in;
   logic [KeyW-1:0]  best_key_ff, best_key_in;
   entry_type        best_ff, best_in;
   logic             best_valid_ff, best_valid_in;
   logic [CW-1:0]    emit_ff, emit_in;
   logic             more_ff, more_in;
   res_type          res_ff, res_in;

   logic [MaskW-1:0] in_mask;
   logic [KeyW-1:0]  cand_key;
   logic             better, chk_last, issue;
   entry_type        pick;
   logic [KeyW-1:0]  pick_key;

   assign in_mask  = req_mask & VarMask;
   assign cand_key = sort_key(rd_data);
   assign chk_last = (CW'(chk_idx_ff) + CW'(1)) == cnt_ff;
   assign better   = chk_valid_ff && (!have_prev_ff || cand_key > prev_key_ff) &&
                     (!best_valid_ff || cand_key < best_key_ff);
   assign pick     = better ? rd_data : best_ff;
   assign pick_key = better ? cand_key : best_key_ff;
   assign issue    = rd_idx_ff < cnt_ff;
   assign rd_addr  = rd_idx_ff[AW-1:0];

   function automatic res_type mk_res(input logic [2:0] st, input logic [CW-1:0] n);
      res_type r;
      r = '0;
      r.status     = st;
      r.term_count = 6'(n);
      r.last       = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rd_idx_in     = rd_idx_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      new_in        = new_ff;
      prev_key_in   = prev_key_ff;
      have_prev_in  = have_prev_ff;
      best_key_in   = best_key_ff;
      best_in       = best_ff;
      best_valid_in = best_valid_ff;
      emit_in       = emit_ff;
      more_in       = more_ff;
      res_in        = res_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[AW-1:0];
      wr_data       = new_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            more_in   = 1'b0;
            rd_idx_in = '0;
            if (req_valid) begin
               new_in.mask   = in_mask;
               new_in.degree = DegW'($countones(in_mask));
               case (req_func)
                  FN_TOGGLE: begin
                     if (cnt_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = new_in;
                        cnt_in   = CW'(1);
                        res_in   = mk_res(ST_ADDED, CW'(1));
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  FN_DUMP: begin
                     if (cnt_ff == '0) begin
                        res_in   = mk_res(ST_DUMPED, cnt_ff);
                        state_in = S_RESP;
                     end else begin
                        emit_in       = '0;
                        have_prev_in  = 1'b0;
                        best_valid_in = 1'b0;
                        state_in      = S_DSCAN;
                     end
                  end
                  FN_CLEAR: begin
                     cnt_in   = '0;
                     res_in   = mk_res(ST_CLEARED, '0);
                     state_in = S_RESP;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               rd_idx_in    = rd_idx_ff + CW'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[AW-1:0];
            end
            if (chk_valid_ff && rd_data.mask == new_ff.mask) begin
               chk_valid_in = 1'b0;
               if (chk_last) begin
                  cnt_in   = cnt_ff - CW'(1);
                  res_in   = mk_res(ST_REMOVED, cnt_ff - CW'(1));
                  state_in = S_RESP;
               end else begin
                  rd_idx_in = CW'(chk_idx_ff) + CW'(1);
                  state_in  = S_COMPACT;
               end
            end else if (chk_valid_ff && chk_last) begin
               chk_valid_in = 1'b0;
               if (cnt_ff >= Full) begin
                  res_in = mk_res(ST_FULL, cnt_ff);
               end else begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
                  res_in = mk_res(ST_ADDED, cnt_ff + CW'(1));
               end
               state_in = S_RESP;
            end
         end
         S_COMPACT: begin
            if (issue) begin
               rd_idx_in    = rd_idx_ff + CW'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[AW-1:0];
            end
            if (chk_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff - AW'(1);
               wr_data = rd_data;
               if (chk_last) begin
                  chk_valid_in = 1'b0;
                  cnt_in       = cnt_ff - CW'(1);
                  res_in       = mk_res(ST_REMOVED, cnt_ff - CW'(1));
                  state_in     = S_RESP;
               end
            end
         end
         S_DSCAN: begin
            if (issue) begin
               rd_idx_in    = rd_idx_ff + CW'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[AW-1:0];
            end
            if (better) begin
               best_in       = rd_data;
               best_key_in   = cand_key;
               best_valid_in = 1'b1;
            end
            if (chk_valid_ff && chk_last) begin
               chk_valid_in       = 1'b0;
               res_in             = mk_res(ST_DUMPED, cnt_ff);
               res_in.term_mask   = pick.mask;
               res_in.term_degree = pick.degree;
               res_in.term_valid  = 1'b1;
               res_in.last        = (emit_ff + CW'(1)) == cnt_ff;
               more_in            = (emit_ff + CW'(1)) != cnt_ff;
               best_key_in        = pick_key;
               state_in           = S_RESP;
            end
         end
         S_RESP: begin
            if (res_ready) begin
               res_valid = 1'b1;
               if (more_ff) begin
                  prev_key_in   = best_key_ff;
                  have_prev_in  = 1'b1;
                  best_valid_in = 1'b0;
                  emit_in       = emit_ff + CW'(1);
                  rd_idx_in     = '0;
                  state_in      = S_DSCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         chk_valid_ff <= 1'b0;
         more_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_valid_ff <= chk_valid_in;
         more_ff      <= more_in;
      end
      rd_idx_ff     <= rd_idx_in;
      chk_idx_ff    <= chk_idx_in;
      new_ff        <= new_in;
      prev_key_ff   <= prev_key_in;
      have_prev_ff  <= have_prev_in;
      best_key_ff   <= best_key_in;
      best_ff       <= best_in;
      best_valid_ff <= best_valid_in;
      emit_ff       <= emit_in;
      res_ff        <= res_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Full) else $error("term count beyond depth");
   a_res_only_ready: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res_ready && state_ff == S_RESP)
      else $error("result issued without room");
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CW'(wr_addr) < cnt_in) else $error("write outside held terms");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_COMPACT) |=>
      (cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + CW'(1) ||
       cnt_ff == $past(cnt_ff) - CW'(1))) else $error("toggle moved count by more than one");
endmodule
`default_nettype wire

>>> design/gf2_monomial_set_toggle_sort_core.sv
// Top level of the monomial set toggle/sort core: sequencer, term store and
// response register. Depends on mst_pkg, mst_if, mst_mem and mst_seq.
`default_nettype none
// Holds a Boolean polynomial in algebraic normal form as up to DEPTH distinct
// monomials (variable masks, bits at or above VARS ignored) in a single-port-
// write, registered-read term store. A toggle transaction scans the n held
// terms for a match: on a hit the entry is removed and the later entries are
// shifted down one per cycle, on a miss the term is appended (or dropped with
// status full when DEPTH terms are held); the scan reads one held term per
// cycle from the store. A dump transaction returns every held term ordered
// by degree, ties resolved by the lowest differing variable, as n responses
// with last on the final one; each term is found by a selection pass over
// the store, and a dump is held up by response back-pressure. An empty dump
// gives one response with term_valid low. A clear transaction empties the
// set at once. Requests are taken only between transactions; a finished
// response sits in an output register so the next request can be accepted
// while it waits. Unused func codes are ignored and give no response.
module gf2_monomial_set_toggle_sort_core import mst_pkg::*; #(
   parameter int VARS  = MST_VARS,
   parameter int DEPTH = MST_DEPTH
) (
   input wire logic  clock,
   input wire logic  reset,
   mst_req_if.sink   req_ch,
   mst_rsp_if.source rsp_ch
);
   localparam int AW = $clog2(DEPTH);

   logic            res_valid, res_ready;
   res_type         res;
   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_data;

   // response holding register
   logic            rsp_valid_ff, rsp_valid_in;
   res_type         rsp_ff, rsp_in;

   mst_seq #(.VARS(VARS), .DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_mask  (req_ch.mono_mask),
      .req_ready (req_ch.ready),
      .res_ready (res_ready),
      .res_valid (res_valid),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   mst_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // room when empty or when the held transaction leaves this cycle
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_ff.status;
   assign rsp_ch.term_mask   = rsp_ff.term_mask;
   assign rsp_ch.term_degree = rsp_ff.term_degree;
   assign rsp_ch.term_valid  = rsp_ff.term_valid;
   assign rsp_ch.term_count  = rsp_ff.term_count;
   assign rsp_ch.last        = rsp_ff.last;
endmodule
`default_nettype wire
